@@ hw/rtl/hfc_pkg.sv @@
// ----------------------------------------------------------------------------
// hfc_pkg: shared types and constants for the half/single converter
// Field widths, function codes and special bit patterns.
// ----------------------------------------------------------------------------
package hfc_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic {
    FUNC_S2H = 1'b0,
    FUNC_H2S = 1'b1
  } func_t;

  localparam logic [14:0] HalfInf  = 15'h7C00;
  localparam logic [14:0] HalfNan  = 15'h7C01;
  localparam logic [31:0] SingleQnan = 32'h7FC0_0000;
  localparam logic [30:0] SingleInf  = 31'h7F80_0000;

endpackage

@@ hw/rtl/half_float_converter_top.sv @@
// ----------------------------------------------------------------------------
// half_float_converter_top: binary16 <-> binary32 converter
// Registered input, single-pass conversion, registered result.
// ----------------------------------------------------------------------------
//  channel | ports                        | direction
//  in      | in_valid in_ready in_func in_value | sink
//  out     | out_valid out_ready out_result     | source
//
//  Beats pass input then result register; one beat per cycle unless stalled.
//  The input and result registers form a two-stage pipeline with ready
//  propagating back through both stages when the output stalls.
//  Reset clears both valid flags; payloads are not reset.
// ----------------------------------------------------------------------------
module half_float_converter_top
  import hfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_func,
  input  logic [WordW-1:0] in_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WordW-1:0] out_result
);

  logic             a_vld_r;
  func_t            a_func_r;
  logic [WordW-1:0] a_val_r;
  logic             b_vld_r;
  logic [WordW-1:0] b_res_r;
  logic [WordW-1:0] conv_res;
  logic             b_ready;

  assign b_ready  = !b_vld_r || out_ready;
  assign in_ready = !a_vld_r || b_ready;

  hfc_conv u_conv (
    .func   (a_func_r),
    .value  (a_val_r),
    .result (conv_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (in_ready) a_vld_r <= in_valid;
      if (b_ready) b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_func_r <= func_t'(in_func);
      a_val_r  <= in_value;
    end
    if (b_ready && a_vld_r) b_res_r <= conv_res;
  end

  assign out_valid  = b_vld_r;
  assign out_result = b_res_r;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r && !out_ready |=> b_vld_r && $stable(b_res_r))
    else $error("result beat dropped under stall");
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r && b_ready |=> b_vld_r)
    else $error("stage a did not advance");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> a_vld_r && b_vld_r)
    else $error("stall without full pipe");
`endif

endmodule

@@ hw/rtl/hfc_conv.sv @@
// ----------------------------------------------------------------------------
// hfc_conv: combinational half/single conversion
// Pure logic; one conversion per call, direction chosen by func.
// ----------------------------------------------------------------------------
module hfc_conv
  import hfc_pkg::*;
(
  input  func_t             func,
  input  logic [WordW-1:0]  value,
  output logic [WordW-1:0]  result
);

  // single to half
  logic        s_sgn;
  logic [7:0]  s_ex;
  logic [22:0] s_man;
  logic [15:0] s2h;
  logic [23:0] s_sig;
  logic [7:0]  s_sh;      // -(ce+14) = 113 - ex when ex <= 112
  logic [23:0] s_shifted;

  // half to single
  logic        h_sgn;
  logic [4:0]  h_ex;
  logic [9:0]  h_man;
  logic [31:0] h2s;
  logic [3:0]  lead;
  logic [22:0] h_norm;

  always_comb begin
    s_sgn     = value[31];
    s_ex      = value[30:23];
    s_man     = value[22:0];
    s_sig     = {1'b1, s_man};
    s_sh      = 8'd113 - s_ex;
    s_shifted = s_sig >> s_sh[4:0];
    if (s_ex == 8'hFF) begin
      s2h = {s_sgn, (s_man == '0) ? HalfInf : HalfNan};
    end else if (s_ex > 8'd142) begin
      s2h = {s_sgn, HalfInf};
    end else if (s_ex > 8'd112) begin
      s2h = {s_sgn, 5'(s_ex - 8'd112), s_man[22:13]};
    end else if (s_sh >= 8'd24) begin
      s2h = {s_sgn, 15'd0};
    end else begin
      s2h = {s_sgn, 4'd0, s_shifted[23:13]};
    end
  end

  always_comb begin
    h_sgn = value[15];
    h_ex  = value[14:10];
    h_man = value[9:0];
    lead  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h_man[i]) lead = 4'(i);
    end
    h_norm = 23'({h_man, 13'd0} << (4'd10 - lead));
    if (h_ex == 5'd0) begin
      if (h_man == '0) h2s = {h_sgn, 31'd0};
      else h2s = {h_sgn, 8'({4'd0, lead} + 8'd103), h_norm};
    end else if (h_ex == 5'h1F) begin
      h2s = (h_man != '0) ? SingleQnan : {h_sgn, SingleInf};
    end else begin
      h2s = {h_sgn, 8'({3'd0, h_ex} + 8'd112), h_man, 13'd0};
    end
  end

  assign result = (func == FUNC_H2S) ? h2s : {16'd0, s2h};

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: half/single converter check
// Drives random and corner-case conversions in both directions through the
// valid/ready channels and compares every result beat with a predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import hfc_pkg::*;

  class conv_scoreboard;
    logic [31:0] pending_q[$];
    int          errors;

    function logic [31:0] to_half(logic [31:0] f);
      logic        sgn;
      logic [7:0]  ex;
      logic [22:0] man;
      logic [15:0] top;
      int          ce;
      int          sh;
      logic [23:0] sig;
      sgn = f[31];
      ex  = f[30:23];
      man = f[22:0];
      top = {sgn, 15'h0};
      if (ex == 8'hFF) return {16'h0, top | (man == 0 ? 16'h7C00 : 16'h7C01)};
      ce = int'(ex) - 127;
      if (ce > 15) return {16'h0, top | 16'h7C00};
      if (ce > -15) begin
        return {16'h0, top | (16'(ce + 15) << 10) | 16'(man >> 13)};
      end
      sh = -(ce + 14);
      if (sh >= 24) return {16'h0, top};
      sig = {1'b1, man};
      return {16'h0, top | 16'((sig >> sh) >> 13)};
    endfunction

    function logic [31:0] to_single(logic [15:0] h);
      logic        sgn;
      logic [4:0]  ex;
      logic [9:0]  man;
      logic [31:0] top;
      int          p;
      sgn = h[15];
      ex  = h[14:10];
      man = h[9:0];
      top = {sgn, 31'h0};
      if (ex == 0) begin
        if (man == 0) return top;
        p = 9;
        while (!man[p]) p--;
        return top | (32'(p + 103) << 23) | ((32'(man) << (23 - p)) & 32'h7FFFFF);
      end
      if (ex == 5'h1F) begin
        if (man != 0) return SingleQnan;
        return top | {1'b0, SingleInf};
      end
      return top | (32'(ex + 112) << 23) | (32'(man) << 13);
    endfunction

    function void note_input(func_t fn, logic [31:0] v);
      pending_q.push_back(fn == FUNC_H2S ? to_single(v[15:0]) : to_half(v));
    endfunction

    function void check_result(logic [31:0] r);
      logic [31:0] exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, r);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (exp_r !== r) begin
        $display("%0t: result mismatch, expected %h actual %h", $time, exp_r, r);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_func;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_result;

  conv_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  bit stim_done;

  half_float_converter_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_result(out_result)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // valid drops only on idle cycles, so back-to-back beats keep it high
  task automatic send_beat(func_t fn, logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= fn;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_input(fn, v);
  endtask

  // random single with a biased exponent so every branch gets hit
  function automatic logic [31:0] rand_single();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(5))
      0: v[30:23] = 8'hFF;
      1: v[30:23] = 8'($urandom_range(127 - 40, 127 - 14));
      2: v[30:23] = 8'($urandom_range(127 - 14, 127 + 15));
      3: v[30:23] = 8'($urandom_range(0, 2));
      4: v[22:0]  = $urandom_range(1) ? 23'h0 : v[22:0];
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_half();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(4))
      0: v[14:10] = 5'h1F;
      1: v[14:10] = 5'h0;
      2: v[9:0]   = 10'h0;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] dir_s[$];
    logic [31:0] dir_h[$];
    rst_n = 1'b0; in_valid = 1'b0; in_func = 1'b0; in_value = '0;
    stim_done = 1'b0;
    send_idle_pct = 0; recv_idle_pct = 0;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_s = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
              32'h7FC0_0001, 32'hFFFF_FFFF, 32'h477F_E000, 32'h4780_0000,
              32'h3880_0000, 32'h387F_FFFF, 32'h3380_0000, 32'h3300_0000,
              32'h0000_0001, 32'h3F80_0000};
    dir_h = '{32'h0000_0000, 32'hFFFF_8000, 32'h0000_0001, 32'h0000_03FF,
              32'h0000_7C00, 32'h0000_FC00, 32'h0000_FE01, 32'hABCD_7BFF,
              32'h0000_0400, 32'h0000_8200};
    foreach (dir_s[i]) send_beat(FUNC_S2H, dir_s[i]);
    foreach (dir_h[i]) send_beat(FUNC_H2S, dir_h[i]);

    for (int i = 0; i < 900; i++) begin
      if (i == 300) begin send_idle_pct = 21; recv_idle_pct = 56; end
      if (i == 550) begin send_idle_pct = 56; recv_idle_pct = 21; end
      if (i == 800) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      if ($urandom_range(1)) send_beat(FUNC_H2S, rand_half());
      else send_beat(FUNC_S2H, rand_single());
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_result);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    wait (stim_done);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

@@ half_float_converter_top.f @@
hw/rtl/hfc_pkg.sv
hw/rtl/hfc_conv.sv
hw/rtl/half_float_converter_top.sv
tb/testbench.sv
